// File: hw/rtl/tlhs_pkg.sv
// ----------------------------------------------------------------------------
// tlhs_pkg
// Types, constants and angle tables shared by the steering unit files.
// ----------------------------------------------------------------------------
package tlhs_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int COORD_W       = 24;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int VEC_W         = 57;
    localparam int ROT_W         = 34;
    localparam int PROD_W        = 50;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int LIM_REM_N     = 45;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN    = 2'd1;

    localparam logic [CFG_W-1:0] STEP_LENGTH_RST = 16'd256;
    localparam logic [CFG_W-1:0] MAX_TURN_RST    = 16'd2560;
    localparam logic [CFG_W-1:0] MAX_TURN_LIMIT  = 16'd46080;
    localparam logic [CFG_W-1:0] TURN_RECIP      = 16'd46604;

    localparam logic [31:0]      HALF_TURN   = 32'h8000_0000;
    localparam logic [ROT_W-1:0] QUARTER_POS = 34'sd1073741824;
    localparam logic [ROT_W-1:0] QUARTER_NEG = -34'sd1073741824;
    localparam logic [ROT_W-1:0] INV_GAIN    = 34'sd652032874;

    typedef logic [31:0] t_atan_tab [0:TAB_LEN-1];
    localparam t_atan_tab ATAN_TAB = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef logic [20:0] t_lim_tab [0:LIM_REM_N-1];

    function automatic t_lim_tab build_lim_tab();
        t_lim_tab tab;
        for (int i = 0; i < LIM_REM_N; i++) begin
            tab[i] = 21'((longint'(i) * 64'd4194304 + 64'd45) / 64'd90);
        end
        return tab;
    endfunction

    localparam t_lim_tab LIM_TAB = build_lim_tab();

    typedef struct packed {
        logic signed [COORD_W-1:0] hx;
        logic signed [COORD_W-1:0] hy;
        logic                      hn;
    } t_side;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [31:0]             z;
        logic                    zero;
    } t_vec;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    flip;
    } t_rot;

    typedef struct packed {
        logic signed [COORD_W-1:0] new_x;
        logic signed [COORD_W-1:0] new_y;
    } t_out_item;

endpackage

// File: hw/rtl/tlhs_in_if.sv
// ----------------------------------------------------------------------------
// tlhs_in_if
// Input channel of the steering unit: one item per valid and ready handshake.
// ----------------------------------------------------------------------------
interface tlhs_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [tlhs_pkg::COORD_W-1:0]     head_x;
    logic signed [tlhs_pkg::COORD_W-1:0]     head_y;
    logic signed [tlhs_pkg::COORD_W-1:0]     neck_x;
    logic signed [tlhs_pkg::COORD_W-1:0]     neck_y;
    logic signed [tlhs_pkg::COORD_W-1:0]     target_x;
    logic signed [tlhs_pkg::COORD_W-1:0]     target_y;
    logic                                    has_neck;

    modport source (output valid, head_x, head_y, neck_x, neck_y, target_x, target_y,
                    has_neck, input ready);
    modport sink (input valid, head_x, head_y, neck_x, neck_y, target_x, target_y,
                  has_neck, output ready);
endinterface

// File: hw/rtl/tlhs_out_if.sv
// ----------------------------------------------------------------------------
// tlhs_out_if
// Output channel of the steering unit: one item per valid and ready handshake.
// ----------------------------------------------------------------------------
interface tlhs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tlhs_pkg::COORD_W-1:0] new_x;
    logic signed [tlhs_pkg::COORD_W-1:0] new_y;

    modport source (output valid, new_x, new_y, input ready);
    modport sink (input valid, new_x, new_y, output ready);
endinterface

// File: hw/rtl/turn_limited_head_steering_unit.sv
// ----------------------------------------------------------------------------
// turn_limited_head_steering_unit
// Turn-rate-limited pursuit steering of one head point per item.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock while the output buffer is not full, and
// returns one result item per input item, in order. Each item passes through
// stage A, the vectoring CORDIC, stage D1, the rotation CORDIC, stage M and
// the output register. Both CORDIC units are pipelined, one register per
// iteration: vectoring for both headings and rotation for the new heading.
// A two-entry output buffer lets the pipeline keep accepting items while a
// result waits to be taken. Once both entries are full, the whole pipeline
// and the input stall until the output takes an item. Configuration writes
// are to be made while no items are in flight.
module turn_limited_head_steering_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tlhs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tlhs_pkg::CFG_W-1:0]          i_cfg_data,
    tlhs_in_if.sink                             i_in,
    tlhs_out_if.source                          o_out
);

    localparam int N = tlhs_pkg::CORDIC_STAGES;
    localparam int DW = tlhs_pkg::DIFF_W;
    localparam int VW = tlhs_pkg::VEC_W;
    localparam int RW = tlhs_pkg::ROT_W;
    localparam int CW = tlhs_pkg::COORD_W;
    localparam int PW_M = tlhs_pkg::PROD_W;

    logic en;

    // Configuration and turn limit.
    logic [tlhs_pkg::CFG_W-1:0] r_step_len;
    logic [tlhs_pkg::CFG_W-1:0] r_max_turn;
    logic [tlhs_pkg::CFG_W-1:0] n_mt_sat;
    logic [31:0]                n_q_prod;
    logic [tlhs_pkg::CFG_W-1:0] r_mt_sat;
    logic [10:0]                r_q;
    logic [tlhs_pkg::CFG_W-1:0] n_rem_full;
    logic [5:0]                 n_rem;
    logic [31:0]                r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_len <= tlhs_pkg::STEP_LENGTH_RST;
            r_max_turn <= tlhs_pkg::MAX_TURN_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tlhs_pkg::REG_STEP_LENGTH) begin
                r_step_len <= i_cfg_data;
            end else if (i_cfg_idx == tlhs_pkg::REG_MAX_TURN) begin
                r_max_turn <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_mt_sat = (r_max_turn > tlhs_pkg::MAX_TURN_LIMIT) ? tlhs_pkg::MAX_TURN_LIMIT
                                                           : r_max_turn;
        n_q_prod = n_mt_sat * tlhs_pkg::TURN_RECIP;
        n_rem_full = r_mt_sat - 16'(r_q * 16'd45);
        n_rem = n_rem_full[5:0];
    end

    always_ff @(posedge i_clk) begin
        r_mt_sat <= n_mt_sat;
        r_q      <= n_q_prod[31:21];
        r_lim    <= {r_q, 21'd0} + {11'd0, tlhs_pkg::LIM_TAB[n_rem]};
    end

    // Stage A: differences.
    logic                      r_a_v;
    tlhs_pkg::t_side           r_a_side;
    logic signed [DW-1:0]      r_a_cx, r_a_cy, r_a_tx, r_a_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side.hx <= i_in.head_x;
            r_a_side.hy <= i_in.head_y;
            r_a_side.hn <= i_in.has_neck;
            r_a_cx <= DW'(i_in.head_x) - DW'(i_in.neck_x);
            r_a_cy <= DW'(i_in.head_y) - DW'(i_in.neck_y);
            r_a_tx <= DW'(i_in.target_x) - DW'(i_in.head_x);
            r_a_ty <= DW'(i_in.target_y) - DW'(i_in.head_y);
        end
    end

    // Vectoring CORDIC for both headings.
    function automatic tlhs_pkg::t_vec vec_pre(logic signed [DW-1:0] dx,
                                               logic signed [DW-1:0] dy);
        tlhs_pkg::t_vec v;
        v.x = {{(VW-DW-30){dx[DW-1]}}, dx, 30'd0};
        v.y = {{(VW-DW-30){dy[DW-1]}}, dy, 30'd0};
        v.z = 32'd0;
        v.zero = (dx == '0) && (dy == '0);
        if (dx[DW-1]) begin
            v.x = -v.x;
            v.y = -v.y;
            v.z = tlhs_pkg::HALF_TURN;
        end
        return v;
    endfunction

    logic                 r_v_v [0:N];
    tlhs_pkg::t_side      r_v_side [0:N];
    tlhs_pkg::t_vec       r_v_c [0:N];
    tlhs_pkg::t_vec       r_v_t [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_v[0] <= 1'b0;
        end else if (en) begin
            r_v_v[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_side[0] <= r_a_side;
            r_v_c[0] <= vec_pre(r_a_cx, r_a_cy);
            r_v_t[0] <= vec_pre(r_a_tx, r_a_ty);
        end
    end

    function automatic tlhs_pkg::t_vec vec_step(tlhs_pkg::t_vec v, int i);
        tlhs_pkg::t_vec o;
        logic signed [VW-1:0] xs, ys;
        xs = v.x >>> i;
        ys = v.y >>> i;
        o = v;
        if (!v.y[VW-1]) begin
            o.x = v.x + ys;
            o.y = v.y - xs;
            o.z = v.z + tlhs_pkg::ATAN_TAB[i];
        end else begin
            o.x = v.x - ys;
            o.y = v.y + xs;
            o.z = v.z - tlhs_pkg::ATAN_TAB[i];
        end
        return o;
    endfunction

    for (genvar g = 0; g < N; g++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_v[g+1] <= 1'b0;
            end else if (en) begin
                r_v_v[g+1] <= r_v_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_v_side[g+1] <= r_v_side[g];
                r_v_c[g+1] <= vec_step(r_v_c[g], g);
                r_v_t[g+1] <= vec_step(r_v_t[g], g);
            end
        end
    end

    // Stage D1: wrapped difference, clamped to the turn limit.
    logic                  r_d_v;
    tlhs_pkg::t_side       r_d_side;
    logic [31:0]           r_d_cur, r_d_diff;
    logic [31:0]           n_cur, n_tgt, n_raw, n_diff;
    logic signed [32:0]    n_sd, n_lim;

    always_comb begin
        n_cur = r_v_c[N].zero ? 32'd0 : r_v_c[N].z;
        n_tgt = r_v_t[N].zero ? 32'd0 : r_v_t[N].z;
        n_raw = n_tgt - n_cur;
        n_sd  = {n_raw[31], n_raw};
        n_lim = {1'b0, r_lim};
        if (n_sd > n_lim) begin
            n_diff = r_lim;
        end else if (n_sd < -n_lim) begin
            n_diff = -r_lim;
        end else begin
            n_diff = n_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_v_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side <= r_v_side[N];
            r_d_cur  <= n_cur;
            r_d_diff <= n_diff;
        end
    end

    // Rotation CORDIC for cos and sin of the new heading.
    logic                 r_r_v [0:N];
    tlhs_pkg::t_side      r_r_side [0:N];
    tlhs_pkg::t_rot       r_r [0:N];
    logic [31:0]          n_head;
    logic signed [RW-1:0] n_hz;
    tlhs_pkg::t_rot       n_rot0;

    always_comb begin
        n_head = r_d_cur + r_d_diff;
        n_hz = {{(RW-32){n_head[31]}}, n_head};
        n_rot0.x = tlhs_pkg::INV_GAIN;
        n_rot0.y = '0;
        n_rot0.flip = (n_hz > $signed(tlhs_pkg::QUARTER_POS))
                   || (n_hz < $signed(tlhs_pkg::QUARTER_NEG));
        if (n_rot0.flip) begin
            n_rot0.z = {{(RW-32){~n_head[31]}}, ~n_head[31], n_head[30:0]};
        end else begin
            n_rot0.z = n_hz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v[0] <= 1'b0;
        end else if (en) begin
            r_r_v[0] <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_side[0] <= r_d_side;
            r_r[0] <= n_rot0;
        end
    end

    function automatic tlhs_pkg::t_rot rot_step(tlhs_pkg::t_rot v, int i);
        tlhs_pkg::t_rot o;
        logic signed [RW-1:0] xs, ys;
        xs = v.x >>> i;
        ys = v.y >>> i;
        o = v;
        if (!v.z[RW-1]) begin
            o.x = v.x - ys;
            o.y = v.y + xs;
            o.z = v.z - RW'(tlhs_pkg::ATAN_TAB[i]);
        end else begin
            o.x = v.x + ys;
            o.y = v.y - xs;
            o.z = v.z + RW'(tlhs_pkg::ATAN_TAB[i]);
        end
        return o;
    endfunction

    for (genvar g = 0; g < N; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_r_v[g+1] <= 1'b0;
            end else if (en) begin
                r_r_v[g+1] <= r_r_v[g];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_r_side[g+1] <= r_r_side[g];
                r_r[g+1] <= rot_step(r_r[g], g);
            end
        end
    end

    // Stage M: step length times cos and sin.
    logic                     r_m_v;
    tlhs_pkg::t_side          r_m_side;
    logic signed [PW_M-1:0]   r_m_px, r_m_py;
    logic signed [RW-1:0]     n_c, n_s;
    logic signed [16:0]       n_step;

    always_comb begin
        n_c = r_r[N].flip ? -r_r[N].x : r_r[N].x;
        n_s = r_r[N].flip ? -r_r[N].y : r_r[N].y;
        n_step = {1'b0, r_step_len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_side <= r_r_side[N];
            r_m_px <= PW_M'(n_step * n_c);
            r_m_py <= PW_M'(n_step * n_s);
        end
    end

    // Final add, rounding and saturation.
    function automatic logic signed [CW-1:0] move_sat(logic signed [CW-1:0] h,
                                                      logic signed [PW_M-1:0] p);
        logic signed [PW_M-1:0] rnd;
        logic signed [CW+1:0]   sum;
        rnd = p + PW_M'(64'sd536870912);
        sum = (CW+2)'(h) + (CW+2)'($signed(rnd[PW_M-1:30]));
        if (sum > (CW+2)'(26'sd8388607)) begin
            return 24'sd8388607;
        end else if (sum < -(CW+2)'(26'sd8388608)) begin
            return -24'sd8388608;
        end
        return sum[CW-1:0];
    endfunction

    tlhs_pkg::t_out_item n_res;

    always_comb begin
        if (r_m_side.hn) begin
            n_res.new_x = move_sat(r_m_side.hx, r_m_px);
            n_res.new_y = move_sat(r_m_side.hy, r_m_py);
        end else begin
            n_res.new_x = '0;
            n_res.new_y = '0;
        end
    end

    // Output register with a skid entry.
    logic                r_o_v, r_sk_v;
    tlhs_pkg::t_out_item r_o, r_sk;
    logic                out_take;

    assign en = !r_sk_v;
    assign out_take = !r_o_v || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (out_take) begin
            if (r_sk_v) begin
                r_o_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_o_v <= r_m_v;
            end
        end else if (r_m_v && en) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_o <= r_sk_v ? r_sk : n_res;
        end else if (en) begin
            r_sk <= n_res;
        end
    end

    assign i_in.ready  = en;
    assign o_out.valid = r_o_v;
    assign o_out.new_x = r_o.new_x;
    assign o_out.new_y = r_o.new_y;

endmodule
